// ===== rtl/core/polyev_pkg.sv =====
// Shared types, constants and register map of the polynomial evaluator.
package polyev_pkg;

   localparam int MAX_DEGREE_DEF = 6;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int NUM_COEFS      = 7;
   localparam int VAL_W          = 32;
   localparam int DEG_W          = 3;
   localparam int ADDR_W         = 5;
   localparam int DATA_W         = 32;

   typedef enum logic [DEG_W-1:0] {
      REG_DEGREE,
      REG_COEF_0,
      REG_COEF_1,
      REG_COEF_2,
      REG_COEF_3,
      REG_COEF_4,
      REG_COEF_5,
      REG_COEF_6
   } polyev_reg_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] acc;
      logic signed [VAL_W-1:0] x;
      logic                    ovf;
   } polyev_data_type;

   typedef struct packed {
      logic [DEG_W-1:0]                degree;
      logic [NUM_COEFS-1:0][VAL_W-1:0] coef;
   } polyev_cfg_type;

endpackage

// ===== rtl/core/polyev_csr.sv =====
// Configuration registers (degree and coefficients) behind an APB-style port.
module polyev_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [polyev_pkg::ADDR_W-1:0]   paddr,
   input  logic [polyev_pkg::DATA_W-1:0]   pwdata,
   output logic [polyev_pkg::DATA_W-1:0]   prdata,
   output logic                            pready,
   output polyev_pkg::polyev_cfg_type      cfg
);
   import polyev_pkg::*;

   logic [DEG_W-1:0]                degree_ff;
   logic [NUM_COEFS-1:0][VAL_W-1:0] coef_ff;
   polyev_reg_type                  reg_sel;
   logic                            wr_en;
   logic [DEG_W-1:0]                coef_idx;

   assign reg_sel  = polyev_reg_type'(paddr[ADDR_W-1:2]);
   assign wr_en    = psel & penable & pwrite;
   assign coef_idx = DEG_W'(reg_sel - REG_COEF_0);
   assign pready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= '0;
         coef_ff   <= '0;
      end else if (wr_en) begin
         if (reg_sel == REG_DEGREE) begin
            degree_ff <= pwdata[DEG_W-1:0];
         end else begin
            coef_ff[coef_idx] <= pwdata[VAL_W-1:0];
         end
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_DEGREE: prdata = DATA_W'(degree_ff);
         REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3,
         REG_COEF_4, REG_COEF_5, REG_COEF_6: prdata = coef_ff[coef_idx];
         default: prdata = '0;
      endcase
   end

   assign cfg.degree = degree_ff;
   assign cfg.coef   = coef_ff;

endmodule

// ===== rtl/core/polyev_cell.sv =====
// One Horner step: multiply by x, round, add the coefficient, saturate.
module polyev_cell #(
   parameter int FRAC_BITS = polyev_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  polyev_pkg::polyev_data_type       in_data,
   input  logic signed [polyev_pkg::VAL_W-1:0] coef,
   output logic                              out_valid,
   input  logic                              out_ready,
   output polyev_pkg::polyev_data_type       out_data
);
   import polyev_pkg::*;

   localparam int PROD_W = 2 * VAL_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam logic signed [PROD_W-1:0] HALF = PROD_W'(64'sd1 <<< (FRAC_BITS - 1));
   localparam logic signed [SUM_W-1:0]  VMAX = SUM_W'((65'sd1 <<< (VAL_W - 1)) - 65'sd1);
   localparam logic signed [SUM_W-1:0]  VMIN = SUM_W'(-(65'sd1 <<< (VAL_W - 1)));

   // stage 1: product
   logic                     s1_valid_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [VAL_W-1:0]  x_ff;
   logic                     ovf_ff;
   logic                     s1_ready;

   // stage 2: rounded, accumulated, clamped
   logic                     s2_valid_ff;
   polyev_data_type          res_ff, res_in;
   logic                     s2_ready;

   logic signed [PROD_W-1:0] rnd;
   logic signed [SUM_W-1:0]  sum;

   assign s2_ready = ~s2_valid_ff | out_ready;
   assign s1_ready = ~s1_valid_ff | s2_ready;
   assign in_ready = s1_ready;

   assign prod_in = PROD_W'(in_data.acc) * PROD_W'(in_data.x);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         prod_ff <= prod_in;
         x_ff    <= in_data.x;
         ovf_ff  <= in_data.ovf;
      end
   end

   always_comb begin
      rnd        = (prod_ff + HALF) >>> FRAC_BITS;
      sum        = SUM_W'(rnd) + SUM_W'(coef);
      res_in.x   = x_ff;
      res_in.ovf = ovf_ff;
      res_in.acc = sum[VAL_W-1:0];
      if (sum > VMAX) begin
         res_in.acc = VMAX[VAL_W-1:0];
         res_in.ovf = 1'b1;
      end else if (sum < VMIN) begin
         res_in.acc = VMIN[VAL_W-1:0];
         res_in.ovf = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = res_ff;

endmodule

// ===== rtl/core/polynomial_evaluator.sv =====
// Top level of the Horner polynomial evaluator.
// Evaluates p(x) = c_0 + c_1*x + ... + c_d*x^d on signed fixed-point samples with
// FRAC_BITS fraction bits. The datapath is a chain of MAX_DEGREE Horner cells; each
// cell has a multiplier stage and a round/add/saturate stage, and one sample is accepted
// per clock while the result side keeps taking results.
// Each stage stalls on its own, so bubbles are squeezed out when the result side
// holds off. Coefficients above the degree are fed as zero, which leaves the result
// unchanged; degrees above MAX_DEGREE act as MAX_DEGREE. rsp_overflow is set when
// any step saturated. Registers: degree at 0x00, coef_k at 0x04 + 4*k; change them
// only while no request is in flight.
module polynomial_evaluator #(
   parameter int MAX_DEGREE = polyev_pkg::MAX_DEGREE_DEF,
   parameter int FRAC_BITS  = polyev_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [polyev_pkg::VAL_W-1:0] req_sample_x,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [polyev_pkg::VAL_W-1:0] rsp_poly_value,
   output logic                               rsp_overflow,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [polyev_pkg::ADDR_W-1:0]      paddr,
   input  logic [polyev_pkg::DATA_W-1:0]      pwdata,
   output logic [polyev_pkg::DATA_W-1:0]      prdata,
   output logic                               pready
);
   import polyev_pkg::*;

   polyev_cfg_type  cfg;
   logic [DEG_W-1:0] eff_degree;

   logic            chain_valid [MAX_DEGREE+1];
   logic            chain_ready [MAX_DEGREE+1];
   polyev_data_type chain_data  [MAX_DEGREE+1];

   polyev_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign eff_degree = (32'(cfg.degree) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : cfg.degree;

   assign chain_valid[0]    = req_valid;
   assign req_ready         = chain_ready[0];
   assign chain_data[0].x   = req_sample_x;
   assign chain_data[0].ovf = 1'b0;
   assign chain_data[0].acc = (DEG_W'(MAX_DEGREE) <= eff_degree) ?
                              $signed(cfg.coef[MAX_DEGREE]) : '0;

   for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_cell
      localparam int K = MAX_DEGREE - 1 - i;
      logic signed [VAL_W-1:0] cell_coef;

      assign cell_coef = (DEG_W'(K) <= eff_degree) ? $signed(cfg.coef[K]) : '0;

      polyev_cell #(
         .FRAC_BITS (FRAC_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .coef      (cell_coef),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   assign rsp_valid                = chain_valid[MAX_DEGREE];
   assign chain_ready[MAX_DEGREE]  = rsp_ready;
   assign rsp_poly_value           = chain_data[MAX_DEGREE].acc;
   assign rsp_overflow             = chain_data[MAX_DEGREE].ovf;

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result stage");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_poly_value) && $stable(rsp_overflow))
      else $error("result changed while stalled");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the Horner polynomial evaluator.
module tb;
   import polyev_pkg::*;

   localparam longint VAL_MAX    = 64'sd2147483647;
   localparam longint VAL_MIN    = -64'sd2147483648;
   localparam int     FRAC       = FRAC_BITS_DEF;
   localparam int     NUM_PHASES = 10;
   localparam int     PHASE_REQS = 175;

   typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    ovf;
   } poly_result_type;

   typedef struct packed {
      row_kind_type    kind;
      polyev_reg_type  reg_sel;
      logic [31:0]     data;
      bit              typed;
      poly_result_type want;
   } stim_row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic signed [VAL_W-1:0] req_sample_x;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [VAL_W-1:0] rsp_poly_value;
   logic                    rsp_overflow;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [ADDR_W-1:0]       paddr;
   logic [DATA_W-1:0]       pwdata;
   logic [DATA_W-1:0]       prdata;
   logic                    pready;

   // Register copy used by the predictor.
   logic [DEG_W-1:0]        cfg_degree;
   logic signed [VAL_W-1:0] cfg_coef [NUM_COEFS];

   poly_result_type pending_results[$];
   poly_result_type next_want;
   bit              next_typed;
   bit              send_burst;
   bit              rsp_burst;
   int              mismatches;
   int              result_count;
   stim_row_type    dir_rows[$];

   polynomial_evaluator DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_x   (req_sample_x),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_poly_value (rsp_poly_value),
      .rsp_overflow   (rsp_overflow),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic poly_result_type eval_poly(logic signed [VAL_W-1:0] x);
      longint          acc;
      longint          term;
      int              top;
      poly_result_type r;
      top = (cfg_degree > MAX_DEGREE_DEF) ? MAX_DEGREE_DEF : int'(cfg_degree);
      acc = cfg_coef[top];
      r.ovf = 1'b0;
      for (int k = top - 1; k >= 0; k--) begin
         term = ((acc * longint'(x)) + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
         term = term + longint'(cfg_coef[k]);
         if (term > VAL_MAX) begin
            term = VAL_MAX;
            r.ovf = 1'b1;
         end else if (term < VAL_MIN) begin
            term = VAL_MIN;
            r.ovf = 1'b1;
         end
         acc = term;
      end
      r.value = acc[VAL_W-1:0];
      return r;
   endfunction

   // Random Q16.16 value of random magnitude, now and then a format limit.
   function automatic logic signed [VAL_W-1:0] rand_fixed();
      int          w;
      int          pick;
      logic [31:0] v;
      w = $urandom_range(1, 32);
      pick = $urandom_range(0, 15);
      v = $urandom;
      if (pick == 0) return 32'sh7FFFFFFF;
      if (pick == 1) return 32'sh80000000;
      return $signed(v) >>> (32 - w);
   endfunction

   function automatic stim_row_type wr(polyev_reg_type sel, logic [31:0] data);
      return '{ROW_WRITE, sel, data, 1'b0, '0};
   endfunction

   function automatic stim_row_type smp(logic [31:0] x);
      return '{ROW_SAMPLE, REG_DEGREE, x, 1'b0, '0};
   endfunction

   function automatic stim_row_type chk(logic [31:0] x, logic [31:0] v, logic o);
      return '{ROW_SAMPLE, REG_DEGREE, x, 1'b1, '{v, o}};
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_reg(polyev_reg_type sel, logic [31:0] data);
      drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (sel == REG_DEGREE) cfg_degree = data[DEG_W-1:0];
      else cfg_coef[int'(sel) - 1] = data;
   endtask

   task automatic send_sample(logic signed [VAL_W-1:0] x, bit typed, poly_result_type want);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_sample_x <= x;
      req_valid    <= 1'b1;
      next_typed   <= typed;
      next_want    <= want;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Result side: random stall before each result, none in burst phases.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      poly_result_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            pending_results.push_back(next_typed ? next_want : eval_poly(req_sample_x));
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result %0d with no request pending: value %h ovf %b",
                           $realtime, result_count, rsp_poly_value, rsp_overflow);
            end else begin
               want = pending_results.pop_front();
               if (rsp_poly_value !== want.value || rsp_overflow !== want.ovf) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: result %0d: expected value %h ovf %b, got %h ovf %b",
                              $realtime, result_count, want.value, want.ovf,
                              rsp_poly_value, rsp_overflow);
               end
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("polynomial_evaluator: mismatch");
      $finish;
   end

   initial begin
      int deg;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_sample_x = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      next_typed   = 1'b0;
      next_want    = '0;
      send_burst   = 1'b0;
      rsp_burst    = 1'b0;
      mismatches   = 0;
      result_count = 0;
      cfg_degree   = '0;
      foreach (cfg_coef[k]) cfg_coef[k] = '0;

      dir_rows = '{
         chk(32'h00000000, 32'h00000000, 1'b0),
         chk(32'h7FFFFFFF, 32'h00000000, 1'b0),
         chk(32'h80000000, 32'h00000000, 1'b0),
         wr(REG_COEF_0, 32'h7FFFFFFF),
         chk(32'h12345678, 32'h7FFFFFFF, 1'b0),
         wr(REG_COEF_0, 32'h80000000),
         chk(32'hFFFFFFFF, 32'h80000000, 1'b0),
         wr(REG_COEF_0, 32'h00000000),
         wr(REG_DEGREE, 32'd1),
         wr(REG_COEF_1, 32'h00010000),
         chk(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0),
         chk(32'h80000000, 32'h80000000, 1'b0),
         wr(REG_COEF_1, 32'h00000001),
         chk(32'h00008000, 32'h00000001, 1'b0),
         chk(32'hFFFF8000, 32'h00000000, 1'b0),
         chk(32'h00018000, 32'h00000002, 1'b0),
         chk(32'hFFFE8000, 32'hFFFFFFFF, 1'b0),
         wr(REG_COEF_1, 32'h7FFFFFFF),
         wr(REG_COEF_0, 32'h7FFFFFFF),
         chk(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1),
         chk(32'h80000000, 32'h80000000, 1'b1),
         chk(32'h00000000, 32'h7FFFFFFF, 1'b0),
         wr(REG_COEF_1, 32'h80000000),
         wr(REG_COEF_0, 32'h80000000),
         chk(32'h80000000, 32'h7FFFFFFF, 1'b1),
         wr(REG_DEGREE, 32'd6),
         wr(REG_COEF_2, 32'h7FFFFFFF),
         wr(REG_COEF_3, 32'h7FFFFFFF),
         wr(REG_COEF_4, 32'h7FFFFFFF),
         wr(REG_COEF_5, 32'h7FFFFFFF),
         wr(REG_COEF_6, 32'h7FFFFFFF),
         smp(32'h00010000),
         smp(32'h00024000),
         wr(REG_DEGREE, 32'd7),
         smp(32'h00010000),
         smp(32'h7FFFFFFF),
         smp(32'hFFFF0000),
         wr(REG_DEGREE, 32'd2),
         smp(32'h00020000)
      };

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_WRITE)
            write_reg(dir_rows[i].reg_sel, dir_rows[i].data);
         else
            send_sample(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         deg = (p < 8) ? p : $urandom_range(0, 7);
         write_reg(REG_DEGREE, deg);
         for (int k = 0; k < NUM_COEFS; k++)
            write_reg(polyev_reg_type'(k + 1), rand_fixed());
         send_burst = ($urandom_range(0, 3) == 0);
         rsp_burst  = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_REQS; n++)
            send_sample(rand_fixed(), 1'b0, '0);
         send_burst = 1'b0;
         rsp_burst  = 1'b0;
      end

      drain();
      repeat (2 * MAX_DEGREE_DEF + 8) @(negedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("polynomial_evaluator: match");
      else
         $display("polynomial_evaluator: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/polyev_pkg.sv
rtl/core/polyev_csr.sv
rtl/core/polyev_cell.sv
rtl/core/polynomial_evaluator.sv
tb/tb.sv
